>>> rtl/fpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Shared widths, codes and word types of the partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int NUM_PARTS  = 8;
  localparam int SIZE_WIDTH = 16;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int POL_W      = 2;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;
  localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 1'd1;

  localparam logic [POL_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [CNT_W-1:0] COUNT_RESET  = 4'd8;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [SLOT_W-1:0]     part_slot;
    logic [SIZE_WIDTH-1:0] size_value;
  } fpa_item_t;

  typedef struct packed {
    logic                  granted;
    logic [SLOT_W-1:0]     chosen_slot;
    logic [SIZE_WIDTH-1:0] chosen_size;
    logic [SIZE_WIDTH-1:0] hole_size;
  } fpa_result_t;

  // Search word that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    logic [SIZE_WIDTH-1:0] req;
    logic                  found;
    logic [SLOT_W-1:0]     idx;
    logic [SIZE_WIDTH-1:0] size;
  } fpa_scan_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic [POL_W-1:0]      policy;
    logic [CNT_W-1:0]      count;
    logic [SLOT_W-1:0]     start;
    logic                  load_en;
    logic [SLOT_W-1:0]     load_slot;
    logic [SIZE_WIDTH-1:0] load_size;
    logic                  mark_en;
    logic [SLOT_W-1:0]     mark_slot;
    logic                  clear_all;
  } fpa_ctrl_t;

endpackage : fpa_pkg
`default_nettype wire

>>> rtl/fpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition size and its used flag, and updates the search word
// that passes through it with this partition if it is a better fit.
// ----------------------------------------------------------------------------
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fpa_ctrl_t ctrl,
  input  wire fpa_scan_t scan_in,
  output fpa_scan_t      scan_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0]  MY_COUNT = CNT_W'(CELL_INDEX);

  logic [SIZE_WIDTH-1:0] size;
  logic                  used;
  logic                  fits;
  logic                  better;
  fpa_scan_t             scan_next;

  always_ff @(posedge clk) begin
    if (ctrl.load_en && ctrl.load_slot == MY_SLOT) begin
      size <= ctrl.load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_all) begin
      used <= 1'b0;
    end else if (ctrl.mark_en && ctrl.mark_slot == MY_SLOT) begin
      used <= 1'b1;
    end
  end

  always_comb begin
    fits = scan_in.valid && (MY_COUNT < ctrl.count) && !used && (size >= scan_in.req);
    unique case (ctrl.policy)
      POL_FIRST: better = !scan_in.found;
      POL_BEST:  better = !scan_in.found || (size < scan_in.size);
      POL_WORST: better = !scan_in.found || (size > scan_in.size);
      POL_NEXT:  better = !scan_in.found ||
                          ((scan_in.idx < ctrl.start) && (MY_SLOT >= ctrl.start));
    endcase
    scan_next = scan_in;
    if (fits && better) begin
      scan_next.found = 1'b1;
      scan_next.idx   = MY_SLOT;
      scan_next.size  = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule : fpa_cell
`default_nettype wire

>>> rtl/fixed_partition_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed partition allocator
// Partition table with used flags that grants requests by first, best,
// worst or next fit, built as a row of partition cells.
// ----------------------------------------------------------------------------
// A load or clear word raises no busy. An allocate word raises busy while
// its search word walks the row of 8 cells, one cell per cycle; the result
// is shown on result with done high for one cycle, and busy falls as done
// rises, so the next word may be taken while done is high. No new word is
// taken until the last allocation's result is shown. The result cannot be
// held off, so it must be taken in the cycle it is shown.
module fixed_partition_allocator
  import fpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire fpa_item_t             item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output fpa_result_t                result
);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(NUM_PARTS);

  logic [POL_W-1:0]  fit_policy;
  logic [CNT_W-1:0]  partition_count;
  logic [SLOT_W-1:0] next_start;
  logic [SLOT_W-1:0] next_start_next;
  logic [CNT_W-1:0]  active_count;
  logic [CNT_W-1:0]  after_pick;
  logic              accept;
  fpa_ctrl_t         ctrl;
  fpa_scan_t         head;
  fpa_scan_t         scan_w [NUM_PARTS+1];
  fpa_scan_t         tail;
  fpa_result_t       result_next;

  assign accept    = start && !busy;
  assign scan_w[0] = head;
  assign tail      = scan_w[NUM_PARTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy      <= POLICY_RESET;
      partition_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_POLICY:      fit_policy      <= cfg_data[POL_W-1:0];
        REG_PARTITION_COUNT: partition_count <= cfg_data;
      endcase
    end
  end

  always_comb begin
    active_count = (partition_count > MAX_COUNT) ? MAX_COUNT : partition_count;
    after_pick   = CNT_W'(tail.idx) + CNT_W'(1);

    ctrl.policy    = fit_policy;
    ctrl.count     = active_count;
    ctrl.start     = (CNT_W'(next_start) < active_count) ? next_start : '0;
    ctrl.load_en   = accept && item.func == FUNC_LOAD;
    ctrl.load_slot = item.part_slot;
    ctrl.load_size = item.size_value;
    ctrl.mark_en   = tail.valid && tail.found;
    ctrl.mark_slot = tail.idx;
    ctrl.clear_all = accept && item.func == FUNC_CLEAR;

    head       = '0;
    head.valid = accept && item.func == FUNC_ALLOC;
    head.req   = item.size_value;

    priority if (ctrl.clear_all) begin
      next_start_next = '0;
    end else if (ctrl.mark_en) begin
      next_start_next = (after_pick >= active_count) ? '0 : after_pick[SLOT_W-1:0];
    end else begin
      next_start_next = next_start;
    end

    result_next = '0;
    if (tail.found) begin
      result_next.granted     = 1'b1;
      result_next.chosen_slot = tail.idx;
      result_next.chosen_size = tail.size;
      result_next.hole_size   = tail.size - tail.req;
    end
  end

  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
    fpa_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .scan_in (scan_w[i]),
      .scan_out(scan_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      next_start <= '0;
    end else begin
      next_start <= next_start_next;
      done       <= tail.valid;
      if (head.valid) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_tail_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy)
    else $error("Search word left the row while no allocation was pending.");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && item.func == FUNC_ALLOC) |-> ##(NUM_PARTS+1) done)
    else $error("Allocate word did not give its result on time.");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe held for more than one cycle.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.granted) |->
      (result.chosen_slot == '0 && result.chosen_size == '0 && result.hole_size == '0))
    else $error("Failed request carries nonzero fields.");

  a_hole_bound: assert property (@(posedge clk) disable iff (rst)
    (done && result.granted) |-> (result.hole_size <= result.chosen_size))
    else $error("Hole exceeds the granted partition size.");
`endif

endmodule : fixed_partition_allocator
`default_nettype wire

>>> tb/sv/fixed_partition_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed partition allocator testbench
// Drives load, clear and allocate words into the allocator under all four
// fit policies and a range of partition counts. A shadow copy of the table
// predicts every grant, and each result word is checked field by field.
// ----------------------------------------------------------------------------
module fixed_partition_allocator_tb
  import fpa_pkg::*;
();

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  fpa_item_t item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic done;
  fpa_result_t result;

  logic [SIZE_WIDTH-1:0] shadow_size [NUM_PARTS];
  bit shadow_used [NUM_PARTS];
  int unsigned shadow_rover;
  logic [POL_W-1:0] shadow_policy;
  logic [CNT_W-1:0] shadow_count;
  fpa_result_t grant_queue [$];
  fpa_result_t next_grant;
  int error_count = 0;
  int cycle_count = 0;

  fixed_partition_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (grant_queue.size() == 0) begin
        report_mismatch("result word with none pending", 0, 1);
      end else begin
        next_grant = grant_queue.pop_front();
        if (result.granted !== next_grant.granted) begin
          report_mismatch("granted", 32'(next_grant.granted), 32'(result.granted));
        end
        if (result.chosen_slot !== next_grant.chosen_slot) begin
          report_mismatch("chosen_slot", 32'(next_grant.chosen_slot),
                          32'(result.chosen_slot));
        end
        if (result.chosen_size !== next_grant.chosen_size) begin
          report_mismatch("chosen_size", 32'(next_grant.chosen_size),
                          32'(result.chosen_size));
        end
        if (result.hole_size !== next_grant.hole_size) begin
          report_mismatch("hole_size", 32'(next_grant.hole_size), 32'(result.hole_size));
        end
      end
    end
  end

  function automatic fpa_result_t predict_grant(input logic [SIZE_WIDTH-1:0] req);
    int pick;
    int unsigned lim;
    int unsigned base;
    int unsigned idx;
    logic [SIZE_WIDTH-1:0] hole;
    logic [SIZE_WIDTH-1:0] pick_hole;
    fpa_result_t grant;
    lim = (shadow_count > NUM_PARTS) ? NUM_PARTS : shadow_count;
    pick = -1;
    pick_hole = '0;
    grant = '0;
    if (shadow_policy == POL_NEXT) begin
      base = (shadow_rover < lim) ? shadow_rover : 0;
      for (int unsigned k = 0; k < lim; k++) begin
        idx = base + k;
        if (idx >= lim) idx = idx - lim;
        if (pick < 0 && !shadow_used[idx] && shadow_size[idx] >= req) pick = idx;
      end
    end else begin
      for (int unsigned k = 0; k < lim; k++) begin
        if (!shadow_used[k] && shadow_size[k] >= req) begin
          hole = shadow_size[k] - req;
          if (pick < 0 || (shadow_policy == POL_BEST && hole < pick_hole) ||
              (shadow_policy == POL_WORST && hole > pick_hole)) begin
            pick = k;
            pick_hole = hole;
          end
        end
      end
    end
    if (pick >= 0) begin
      shadow_used[pick] = 1'b1;
      shadow_rover = pick + 1;
      if (shadow_rover >= lim) shadow_rover = 0;
      grant.granted = 1'b1;
      grant.chosen_slot = pick[SLOT_W-1:0];
      grant.chosen_size = shadow_size[pick];
      grant.hole_size = shadow_size[pick] - req;
    end
    return grant;
  endfunction

  task automatic track_word(input fpa_item_t w);
    case (w.func)
      FUNC_LOAD: begin
        shadow_size[w.part_slot] = w.size_value;
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < NUM_PARTS; k++) shadow_used[k] = 1'b0;
        shadow_rover = 0;
      end
      FUNC_ALLOC: begin
        grant_queue.push_back(predict_grant(w.size_value));
      end
      default: ;
    endcase
  endtask

  // Called and returns at a falling edge; start stays high for the next word.
  task automatic send_word(input fpa_item_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    item = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_word(w);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    start = 1'b0;
    while (grant_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_allocator_mode(input logic [CFG_DATA_W-1:0] policy_data,
                                    input logic [CFG_DATA_W-1:0] count_data);
    wait_for_idle();
    cfg_we = 1'b1;
    cfg_index = REG_FIT_POLICY;
    cfg_data = policy_data;
    @(posedge clk);
    shadow_policy = policy_data[POL_W-1:0];
    @(negedge clk);
    cfg_index = REG_PARTITION_COUNT;
    cfg_data = count_data;
    @(posedge clk);
    shadow_count = count_data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic fpa_item_t make_word(input logic [FUNC_W-1:0] func,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [SIZE_WIDTH-1:0] size);
    fpa_item_t w;
    w.func = func;
    w.part_slot = slot;
    w.size_value = size;
    return w;
  endfunction

  function automatic logic [SIZE_WIDTH-1:0] pick_request();
    logic [SIZE_WIDTH-1:0] base;
    logic [SIZE_WIDTH-1:0] off;
    base = shadow_size[SLOT_W'($urandom_range(NUM_PARTS - 1))];
    off = SIZE_WIDTH'($urandom_range(3));
    case ($urandom_range(9))
      0, 1: pick_request = SIZE_WIDTH'($urandom);
      2: pick_request = SIZE_WIDTH'($urandom_range(15));
      3: pick_request = base;
      4: pick_request = base | off;
      default: pick_request = (base > off) ? base - off : '0;
    endcase
  endfunction

  function automatic logic [SIZE_WIDTH-1:0] pick_partition_size();
    case ($urandom_range(7))
      0: pick_partition_size = SIZE_WIDTH'($urandom);
      1: pick_partition_size = shadow_size[SLOT_W'($urandom_range(NUM_PARTS - 1))];
      2: pick_partition_size = $urandom_range(1) ? '1 : '0;
      default: pick_partition_size = SIZE_WIDTH'($urandom_range(4096, 64));
    endcase
  endfunction

  function automatic fpa_item_t random_word();
    fpa_item_t w;
    int unsigned roll;
    roll = $urandom_range(99);
    w.part_slot = SLOT_W'($urandom_range(NUM_PARTS - 1));
    w.size_value = SIZE_WIDTH'($urandom);
    if (roll < 70) begin
      w.func = FUNC_ALLOC;
      w.size_value = pick_request();
    end else if (roll < 82) begin
      w.func = FUNC_LOAD;
      w.size_value = pick_partition_size();
    end else if (roll < 97) begin
      w.func = FUNC_CLEAR;
    end else begin
      w.func = FUNC_NOP;
    end
    return w;
  endfunction

  // Loads every partition, so no scan ever reads an unwritten size, then
  // checks a first-fit grant under the reset settings.
  task automatic test_reset_defaults();
    send_word(make_word(FUNC_LOAD, 3'd0, 16'd100), 0);
    send_word(make_word(FUNC_LOAD, 3'd1, 16'd0), 0);
    send_word(make_word(FUNC_LOAD, 3'd2, 16'hFFFF), 0);
    send_word(make_word(FUNC_LOAD, 3'd3, 16'd300), 0);
    send_word(make_word(FUNC_LOAD, 3'd4, 16'd100), 0);
    send_word(make_word(FUNC_LOAD, 3'd5, 16'd500), 0);
    send_word(make_word(FUNC_LOAD, 3'd6, 16'd200), 0);
    send_word(make_word(FUNC_LOAD, 3'd7, 16'd300), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'hFFFF), 0);
    send_word(make_word(FUNC_NOP, 3'd7, 16'hFFFF), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'hFFFF), 0);
  endtask

  task automatic policy_case(input logic [POL_W-1:0] policy);
    set_allocator_mode(CFG_DATA_W'(policy), COUNT_RESET);
    send_word(make_word(FUNC_CLEAR, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd100), 0);
  endtask

  task automatic test_policies();
    policy_case(POL_FIRST);
    policy_case(POL_BEST);
    policy_case(POL_WORST);
    policy_case(POL_NEXT);
  endtask

  // Count of zero fails everything, a count above the table saturates, and
  // a next-fit pointer past the count restarts the scan at zero.
  task automatic test_count_limits();
    set_allocator_mode(CFG_DATA_W'(POL_FIRST), 4'd0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
    set_allocator_mode(CFG_DATA_W'(POL_NEXT), 4'd15);
    send_word(make_word(FUNC_CLEAR, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
    set_allocator_mode(CFG_DATA_W'(POL_NEXT), 4'd1);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_CLEAR, 3'd0, 16'd0), 0);
    send_word(make_word(FUNC_ALLOC, 3'd0, 16'd0), 0);
  endtask

  task automatic random_block(input logic [POL_W-1:0] policy, input int unsigned idle_pct,
                              input int unsigned words);
    logic [CFG_DATA_W-POL_W-1:0] junk;
    logic [CFG_DATA_W-1:0] count_data;
    junk = (CFG_DATA_W-POL_W)'($urandom_range(3));
    count_data = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(15)) : COUNT_RESET;
    set_allocator_mode({junk, policy}, count_data);
    repeat (words) begin
      send_word(random_word(), idle_pct);
      if ($urandom_range(99) == 0) wait_for_idle();
    end
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned words);
    random_block(POL_FIRST, idle_pct, words / 4);
    random_block(POL_BEST, idle_pct, words / 4);
    random_block(POL_WORST, idle_pct, words / 4);
    random_block(POL_NEXT, idle_pct, words / 4);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < NUM_PARTS; k++) begin
      shadow_size[k] = '0;
      shadow_used[k] = 1'b0;
    end
    shadow_rover = 0;
    shadow_policy = POLICY_RESET;
    shadow_count = COUNT_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_policies();
    test_count_limits();
    test_random_phase(0, 420);
    test_random_phase(85, 420);
    test_random_phase(10, 420);

    wait_for_idle();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
